@@ hdl/flm_pkg.sv @@
`default_nettype none

package flm_pkg;

    // Bank size. The request fields are fixed at four bits each.
    localparam int LOCK_COUNT = 16;
    localparam int NUM_AGENTS = 16;
    localparam int NUM_SLOTS  = LOCK_COUNT * NUM_AGENTS;

    localparam int MODE_W   = 2;
    localparam int FIELD_W  = 4;
    localparam int STATUS_W = 3;

    localparam int LOCK_W  = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
    localparam int AGENT_W = $clog2(NUM_AGENTS);
    localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam logic [MODE_W-1:0] MODE_TRY     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACQUIRE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_ACQUIRED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_QUEUED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FREED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_HANDED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_MISUSE   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_QUERIED  = 3'd6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
    } flm_cmd_t;

    // Flat index of the (lock, agent) entry in the per-agent tables.
    function automatic logic [SLOT_W-1:0] slot_of(
        input logic [LOCK_W-1:0]  lk,
        input logic [AGENT_W-1:0] ag
    );
        logic [SLOT_W-1:0] base;
        base = SLOT_W'(lk) * SLOT_W'(NUM_AGENTS);
        return base + SLOT_W'(ag);
    endfunction

endpackage

`default_nettype wire

@@ hdl/flm_if.sv @@
`default_nettype none

interface flm_req_if
    import flm_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [FIELD_W-1:0] lock_index;
    logic [FIELD_W-1:0] agent_id;

    modport source (output valid, output mode, output lock_index, output agent_id,
                    input ready);
    modport sink   (input valid, input mode, input lock_index, input agent_id,
                    output ready);
endinterface

interface flm_rsp_if
    import flm_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                lock_free;
    logic                woken_valid;
    logic [FIELD_W-1:0]  woken_agent;

    modport source (output valid, output status, output lock_free, output woken_valid,
                    output woken_agent, input ready);
    modport sink   (input valid, input status, input lock_free, input woken_valid,
                    input woken_agent, output ready);
endinterface

`default_nettype wire

@@ hdl/flm_ctrl.sv @@
`default_nettype none

module flm_ctrl
    import flm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output flm_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        in_ready    = (state_reg == S_IDLE);
        cmd.capture = in_ready && in_valid;
        // The update waits until the result register is empty or being emptied.
        cmd.exec    = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);
        out_valid   = out_valid_reg;

        case (state_reg)
            S_IDLE:  state_next = cmd.capture ? S_EXEC : S_IDLE;
            S_EXEC:  state_next = cmd.exec ? S_IDLE : S_EXEC;
            default: state_next = S_IDLE;
        endcase

        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_exec_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> out_valid_reg)
        else $error("result register not loaded after an update");

    a_capture_starts_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == S_EXEC))
        else $error("accepted request did not move to the update state");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) && !cmd.exec |=> (state_reg == S_EXEC) && !in_ready)
        else $error("request accepted while an update is pending");

endmodule

`default_nettype wire

@@ hdl/flm_dp.sv @@
`default_nettype none

module flm_dp
    import flm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire flm_cmd_t            cmd,
    input  wire logic [MODE_W-1:0]   in_mode,
    input  wire logic [FIELD_W-1:0]  in_lock,
    input  wire logic [FIELD_W-1:0]  in_agent,
    output logic [STATUS_W-1:0]      status,
    output logic                     lock_free,
    output logic                     woken_valid,
    output logic [FIELD_W-1:0]       woken_agent
);

    // Captured request.
    logic [MODE_W-1:0]  mode_reg;
    logic [FIELD_W-1:0] lock_reg;
    logic [FIELD_W-1:0] agent_reg;
    logic [AGENT_W-1:0] link_rd_reg;

    // Per-lock tail and holder.
    logic [LOCK_COUNT-1:0] tail_valid_reg;
    logic [AGENT_W-1:0]    tail_agent_reg [LOCK_COUNT];
    logic [AGENT_W-1:0]    holder_reg     [LOCK_COUNT];

    // Per (lock, agent): queued mark, and whether a successor link is present.
    // The successor agent itself lives in the link memory.
    logic [NUM_SLOTS-1:0] queued_reg;
    logic [NUM_SLOTS-1:0] present_reg;
    logic [AGENT_W-1:0]   link_mem [NUM_SLOTS];

    // Result register.
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                lock_free_reg, lock_free_next;
    logic                woken_valid_reg, woken_valid_next;
    logic [FIELD_W-1:0]  woken_agent_reg, woken_agent_next;

    logic               range_ok;
    logic [LOCK_W-1:0]  lk;
    logic [AGENT_W-1:0] ag;
    logic [SLOT_W-1:0]  own_slot, pred_slot, hold_slot;
    logic               tv_cur, tv_after, qm_own, link_own;
    logic               do_grant, do_link, do_release, do_hand;

    always_comb
    begin
        range_ok  = (32'(lock_reg) < LOCK_COUNT) && (32'(agent_reg) < NUM_AGENTS);
        lk        = LOCK_W'(lock_reg);
        ag        = AGENT_W'(agent_reg);
        own_slot  = slot_of(lk, ag);
        pred_slot = slot_of(lk, tail_agent_reg[lk]);
        hold_slot = slot_of(lk, holder_reg[lk]);
        tv_cur    = tail_valid_reg[lk];
        qm_own    = queued_reg[own_slot];
        link_own  = present_reg[own_slot];

        do_grant   = 1'b0;
        do_link    = 1'b0;
        do_release = 1'b0;
        do_hand    = 1'b0;
        status_next = ST_QUERIED;

        if (!range_ok)
        begin
            status_next = ST_MISUSE;
        end
        else
        begin
            case (mode_reg)
                MODE_TRY, MODE_ACQUIRE:
                begin
                    if (qm_own)
                    begin
                        status_next = ST_MISUSE;
                    end
                    else if (!tv_cur)
                    begin
                        do_grant    = cmd.exec;
                        status_next = ST_ACQUIRED;
                    end
                    else if (mode_reg == MODE_TRY)
                    begin
                        status_next = ST_BUSY;
                    end
                    else
                    begin
                        do_link     = cmd.exec;
                        status_next = ST_QUEUED;
                    end
                end
                MODE_RELEASE:
                begin
                    if (!tv_cur || (holder_reg[lk] != ag))
                    begin
                        status_next = ST_MISUSE;
                    end
                    else
                    begin
                        do_release  = cmd.exec;
                        do_hand     = cmd.exec && link_own;
                        status_next = link_own ? ST_HANDED : ST_FREED;
                    end
                end
                default:
                begin
                    status_next = ST_QUERIED;
                end
            endcase
        end

        if (status_next == ST_ACQUIRED)
        begin
            tv_after = 1'b1;
        end
        else if (status_next == ST_FREED)
        begin
            tv_after = 1'b0;
        end
        else
        begin
            tv_after = tv_cur;
        end

        lock_free_next   = range_ok && !tv_after;
        woken_valid_next = (status_next == ST_HANDED);
        woken_agent_next = woken_valid_next ? FIELD_W'(link_rd_reg) : '0;
    end

    // Request capture, result register and link memory.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg    <= in_mode;
            lock_reg    <= in_lock;
            agent_reg   <= in_agent;
            link_rd_reg <= link_mem[slot_of(LOCK_W'(in_lock), AGENT_W'(in_agent))];
        end
        if (do_link)
        begin
            link_mem[pred_slot] <= ag;
        end
        if (cmd.exec)
        begin
            status_reg      <= status_next;
            lock_free_reg   <= lock_free_next;
            woken_valid_reg <= woken_valid_next;
            woken_agent_reg <= woken_agent_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_valid_reg <= '0;
            queued_reg     <= '0;
            present_reg    <= '0;
            for (int i = 0; i < LOCK_COUNT; i++)
            begin
                tail_agent_reg[i] <= '0;
                holder_reg[i]     <= '0;
            end
        end
        else
        begin
            if (do_grant)
            begin
                tail_valid_reg[lk]    <= 1'b1;
                tail_agent_reg[lk]    <= ag;
                holder_reg[lk]        <= ag;
                present_reg[own_slot] <= 1'b0;
                queued_reg[own_slot]  <= 1'b1;
            end
            if (do_link)
            begin
                tail_agent_reg[lk]     <= ag;
                present_reg[pred_slot] <= 1'b1;
                present_reg[own_slot]  <= 1'b0;
                queued_reg[own_slot]   <= 1'b1;
            end
            if (do_release)
            begin
                present_reg[own_slot] <= 1'b0;
                queued_reg[own_slot]  <= 1'b0;
                if (do_hand)
                begin
                    holder_reg[lk] <= link_rd_reg;
                end
                else
                begin
                    tail_valid_reg[lk] <= 1'b0;
                end
            end
        end
    end

    assign status      = status_reg;
    assign lock_free   = lock_free_reg;
    assign woken_valid = woken_valid_reg;
    assign woken_agent = woken_agent_reg;

    // The holder of a taken lock always carries its queued mark.
    a_holder_marked: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && range_ok && tv_cur |-> queued_reg[hold_slot])
        else $error("holder of a taken lock is not marked queued");

    // Queuing only happens behind a tail that is itself queued.
    a_link_behind_queued: assert property (@(posedge clk) disable iff (!rst_n)
        do_link |-> queued_reg[pred_slot] && (pred_slot != own_slot))
        else $error("agent linked behind a tail that is not queued");

    // Only an agent that is not yet in line gets linked, and only on a taken lock.
    a_link_on_taken: assert property (@(posedge clk) disable iff (!rst_n)
        do_link |-> tv_cur && !qm_own)
        else $error("agent linked on a free lock or while already queued");

endmodule

`default_nettype wire

@@ hdl/fifo_queue_lock_manager.sv @@
// Bank of FIFO queue locks with first-come hand-over between agents.
//
// Channels: req carries one request (mode, lock_index, agent_id); rsp carries
// exactly one result per request (status, lock_free, woken_valid, woken_agent).
// Both use valid/ready; a transaction happens on a rising edge with both high.
//
// Sequencing: accepting a request also reads the successor-link memory into a
// register; a later update then writes the lock tables and loads the result
// register, and only after that update does req.ready rise for the next
// request. The next request is accepted while a result still waits in that
// register; if rsp stays stalled, the following update waits and req.ready
// stays low.
//
// Reset: rst_n is asynchronous, active low. Every lock comes out free, with no
// agent queued and no successor linked; the block is ready at once, with no
// clearing pass.
`default_nettype none

module fifo_queue_lock_manager
    import flm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    flm_req_if.sink   req,
    flm_rsp_if.source rsp
);

    flm_cmd_t cmd;

    flm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    flm_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_mode     (req.mode),
        .in_lock     (req.lock_index),
        .in_agent    (req.agent_id),
        .status      (rsp.status),
        .lock_free   (rsp.lock_free),
        .woken_valid (rsp.woken_valid),
        .woken_agent (rsp.woken_agent)
    );

endmodule

`default_nettype wire
